### src/afc_pkg.sv
package afc_pkg;

    localparam int TIME_WIDTH_DEF = 26;
    localparam int PERIOD_W       = 26;
    localparam int FREQ_W         = 32;
    localparam int PTA_W          = 8;
    localparam int EDGE_W         = 9;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 26;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PERIODS = 1'd0;
    localparam t_cfg_idx CFG_TIMEOUT = 1'd1;

    localparam logic [PTA_W-1:0]    PTA_RESET     = 8'd10;
    localparam logic [PERIOD_W-1:0] TIMEOUT_RESET = 26'd300000;

    // 1e6 us per second times 16 for the q4 fraction
    localparam logic [FREQ_W-1:0] Q4_PER_PERIOD = 32'd16000000;
    localparam logic [FREQ_W-1:0] FREQ_SAT      = {FREQ_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### src/afc_if.sv
interface afc_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic edge_req;
    logic us_tick;

    modport source (output valid, output start_req, output edge_req, output us_tick,
                    input ready);
    modport sink (input valid, input start_req, input edge_req, input us_tick,
                  output ready);
endinterface

interface afc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          timed_out;
    logic [afc_pkg::PERIOD_W-1:0]  period_us;
    logic [afc_pkg::FREQ_W-1:0]    frequency_q4;

    modport source (output valid, output timed_out, output period_us, output frequency_q4,
                    input ready);
    modport sink (input valid, input timed_out, input period_us, input frequency_q4,
                  output ready);
endinterface

interface afc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [afc_pkg::CFG_IDX_W-1:0]  index;
    logic [afc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/afc_div.sv
// restoring divider, one quotient bit per cycle
module afc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [afc_pkg::FREQ_W-1:0]    i_dividend,
    input  logic [afc_pkg::PERIOD_W-1:0]  i_divisor,
    output afc_pkg::t_div_stat            o_stat,
    output logic [afc_pkg::FREQ_W-1:0]    o_quotient
);
    localparam int QW  = afc_pkg::FREQ_W;
    localparam int DW  = afc_pkg::PERIOD_W;
    localparam int CNW = $clog2(QW + 1);

    logic [QW-1:0]  r_quo;
    logic [DW:0]    r_rem;
    logic [DW-1:0]  r_div;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [DW:0] rem_sh;
    logic        fits;

    always_comb begin
        rem_sh = {r_rem[DW-1:0], r_quo[QW-1]};
        fits   = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_cnt  <= CNW'(QW);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_div}) : rem_sh;
            r_quo <= {r_quo[QW-2:0], fits};
            r_cnt <= r_cnt - CNW'(1);
            if (r_cnt == CNW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

### src/averaged_frequency_counter.sv
// Averaging reciprocal frequency counter. Each input beat carries a start, an edge and a
// microsecond tick flag, handled in that order. Start arms a measurement and clears the
// counters; the first edge after start sets the time origin and the edge after
// periods_to_average more periods ends it, giving period_us (first to last edge) and
// frequency_q4 = 16e6 * periods_to_average / period_us with 4 fraction bits, truncated,
// saturated to all ones for a zero period. If the tick count since start reaches timeout_us
// first, a timed-out result with zero fields is sent. Edges and ticks while not armed do
// nothing. Rate: one input beat per clock while measuring; a finished measurement with a
// nonzero period holds the input off while the restoring divider produces one quotient
// bit per cycle. Input ready is also low while a result waits in the
// output register and the output side is stalled. Configuration writes are taken at any
// time and must only be issued while no measurement is running.
module averaged_frequency_counter #(
    parameter int TIME_WIDTH = afc_pkg::TIME_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    afc_in_if.sink      i_in,
    afc_out_if.source   o_out,
    afc_cfg_if.sink     i_cfg
);
    localparam int PW    = afc_pkg::PERIOD_W;
    localparam int FW    = afc_pkg::FREQ_W;
    localparam int EW    = afc_pkg::EDGE_W;
    localparam int CMP_W = (TIME_WIDTH > PW) ? TIME_WIDTH : PW;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
    localparam logic [EW-1:0]         EDGE_MAX = {EW{1'b1}};

    typedef enum logic {
        ST_RUN,
        ST_DIV
    } t_state;

    // configuration registers
    logic [afc_pkg::PTA_W-1:0] r_pta;
    logic [PW-1:0]             r_timeout;

    // measurement state
    t_state                r_state, n_state;
    logic                  r_armed, n_armed;
    logic [EW-1:0]         r_edges, n_edges;
    logic [TIME_WIDTH-1:0] r_since_start, n_since_start;
    logic [TIME_WIDTH-1:0] r_since_first, n_since_first;

    // output register
    logic          r_out_valid, n_out_valid;
    logic          r_out_tmo, n_out_tmo;
    logic [PW-1:0] r_out_per, n_out_per;
    logic [FW-1:0] r_out_freq, n_out_freq;

    // divider hookup
    logic               div_start;
    logic [FW-1:0]      div_num;
    afc_pkg::t_div_stat div_stat;
    logic [FW-1:0]      div_quo;

    logic          out_free;
    logic          in_fire;
    logic          meas_done;
    logic          meas_tmo;
    logic [PW-1:0] meas_per;

    // output register can take a new result this cycle
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_RUN) && out_free;
    assign in_fire = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // numerator: 16e6 scaled by the period count, always fits in 32 bits
    assign div_num = FW'(FW'(r_pta) * afc_pkg::Q4_PER_PERIOD);

    afc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (meas_per),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // one input beat: start, then edge, then tick
    always_comb begin
        n_armed       = r_armed;
        n_edges       = r_edges;
        n_since_start = r_since_start;
        n_since_first = r_since_first;
        meas_done     = 1'b0;
        meas_tmo      = 1'b0;
        meas_per      = '0;
        if (in_fire) begin
            if (i_in.start_req) begin
                n_armed       = 1'b1;
                n_edges       = '0;
                n_since_start = '0;
                n_since_first = '0;
            end
            if (i_in.edge_req && n_armed) begin
                if (n_edges == '0) begin
                    n_since_first = '0;
                end
                if (n_edges != EDGE_MAX) begin
                    n_edges = n_edges + EW'(1);
                end
                if (n_edges > EW'(r_pta)) begin
                    n_armed   = 1'b0;
                    meas_done = 1'b1;
                    meas_per  = PW'(n_since_first);
                end
            end
            // a finished measurement has already disarmed, so its tick is dropped
            if (i_in.us_tick && n_armed) begin
                if (n_since_start != TIME_MAX) begin
                    n_since_start = n_since_start + TIME_WIDTH'(1);
                end
                if (n_edges != '0 && n_since_first != TIME_MAX) begin
                    n_since_first = n_since_first + TIME_WIDTH'(1);
                end
                if (CMP_W'(n_since_start) >= CMP_W'(r_timeout) ||
                    n_since_start == TIME_MAX) begin
                    n_armed  = 1'b0;
                    meas_tmo = 1'b1;
                end
            end
        end
    end

    // sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_tmo   = r_out_tmo;
        n_out_per   = r_out_per;
        n_out_freq  = r_out_freq;
        div_start   = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (meas_tmo) begin
                    n_out_valid = 1'b1;
                    n_out_tmo   = 1'b1;
                    n_out_per   = '0;
                    n_out_freq  = '0;
                end else if (meas_done) begin
                    n_out_tmo = 1'b0;
                    n_out_per = meas_per;
                    if (meas_per == '0) begin
                        // zero period saturates, no division
                        n_out_valid = 1'b1;
                        n_out_freq  = afc_pkg::FREQ_SAT;
                    end else begin
                        // final period goes straight into the divider
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done && !div_stat.busy && out_free) begin
                    n_out_valid = 1'b1;
                    n_out_freq  = div_quo;
                    n_state     = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_RUN;
            r_armed       <= 1'b0;
            r_edges       <= '0;
            r_since_start <= '0;
            r_since_first <= '0;
            r_out_valid   <= 1'b0;
            r_pta         <= afc_pkg::PTA_RESET;
            r_timeout     <= afc_pkg::TIMEOUT_RESET;
        end else begin
            r_state       <= n_state;
            r_armed       <= n_armed;
            r_edges       <= n_edges;
            r_since_start <= n_since_start;
            r_since_first <= n_since_first;
            r_out_valid   <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    afc_pkg::CFG_PERIODS: r_pta     <= i_cfg.data[afc_pkg::PTA_W-1:0];
                    afc_pkg::CFG_TIMEOUT: r_timeout <= PW'(i_cfg.data);
                    default: ;
                endcase
            end
        end
        r_out_tmo  <= n_out_tmo;
        r_out_per  <= n_out_per;
        r_out_freq <= n_out_freq;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.timed_out    = r_out_tmo;
    assign o_out.period_us    = r_out_per;
    assign o_out.frequency_q4 = r_out_freq;

endmodule
